// ===== hw/rtl/shbi_pkg.sv =====
package shbi_pkg;

    // Hash width as fixed by the fields of the stream
    localparam int unsigned HASH_WIDTH_DEF = 32;

    localparam int unsigned CHAR_W  = 8;
    localparam int unsigned CFG_IDX_W = 2;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_HASH_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BUCKETS   = 2'd1;

    // Hash mode codes
    localparam logic MODE_POLY = 1'b0;
    localparam logic MODE_MX   = 1'b1;

    // Multipliers and seeds
    localparam int unsigned POLY_SHIFT = 5;                 // 31*h = 32*h - h
    localparam int unsigned MX_MULT_H  = 54059;
    localparam logic signed [17:0] MX_MULT_C = 18'sd76963;
    localparam int unsigned SEED_POLY  = 0;
    localparam int unsigned SEED_MX    = 37;

    localparam int unsigned BUCKETS_RST = 1024;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_DELIVER
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic item_accept;   // input word taken this cycle
        logic div_step;      // one restoring division step
        logic out_load;      // move finished result to output register
    } cmd_t;

endpackage

// ===== hw/rtl/shbi_ctrl.sv =====
module shbi_ctrl #(
    parameter int unsigned HASH_WIDTH = shbi_pkg::HASH_WIDTH_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    input  logic             s_tlast,
    output logic             s_tready,
    input  logic             m_tready,
    output logic             m_tvalid,
    output shbi_pkg::cmd_t   cmd
);

    localparam int unsigned CNT_W = $clog2(HASH_WIDTH);

    shbi_pkg::state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= shbi_pkg::ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            shbi_pkg::ST_IDLE: begin
                if (s_tvalid && s_tlast) state_next = shbi_pkg::ST_DIVIDE;
            end
            shbi_pkg::ST_DIVIDE: begin
                if (cnt_reg == '0) state_next = shbi_pkg::ST_DELIVER;
            end
            shbi_pkg::ST_DELIVER: begin
                if (!out_valid_reg || m_tready) state_next = shbi_pkg::ST_IDLE;
            end
            default: state_next = shbi_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_tready        = 1'b0;
        cmd.item_accept = 1'b0;
        cmd.div_step    = 1'b0;
        cmd.out_load    = 1'b0;
        unique case (state_reg)
            shbi_pkg::ST_IDLE: begin
                s_tready        = 1'b1;
                cmd.item_accept = s_tvalid;
            end
            shbi_pkg::ST_DIVIDE: begin
                cmd.div_step = 1'b1;
            end
            shbi_pkg::ST_DELIVER: begin
                cmd.out_load = !out_valid_reg || m_tready;
            end
            default: ;
        endcase
    end

    always_comb begin
        cnt_next = cnt_reg;
        if (cmd.item_accept && s_tlast) begin
            cnt_next = CNT_W'(HASH_WIDTH - 1);
        end else if (cmd.div_step) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;

endmodule

// ===== hw/rtl/shbi_dp.sv =====
module shbi_dp #(
    parameter int unsigned HASH_WIDTH = shbi_pkg::HASH_WIDTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  shbi_pkg::cmd_t                      cmd,
    input  logic [shbi_pkg::CHAR_W-1:0]         char_byte,
    input  logic                                char_valid,
    input  logic                                word_end,
    input  logic                                cfg_we,
    input  logic [shbi_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [HASH_WIDTH-1:0]               cfg_wdata,
    output logic [HASH_WIDTH-1:0]               raw_hash,
    output logic [HASH_WIDTH-1:0]               bucket_index
);

    localparam int unsigned CT_W = shbi_pkg::CHAR_W + $bits(shbi_pkg::MX_MULT_C);

    logic                  mode_reg;
    logic [HASH_WIDTH-1:0] buckets_reg;
    logic [HASH_WIDTH-1:0] hash_reg, hash_next;
    logic [HASH_WIDTH-1:0] raw_reg;
    logic [HASH_WIDTH-1:0] dvd_reg;    // dividend, shifted out msb first
    logic [HASH_WIDTH-1:0] rem_reg;
    logic [HASH_WIDTH-1:0] out_raw_reg, out_bucket_reg;

    logic [HASH_WIDTH-1:0] seed, seed_new;
    logic [HASH_WIDTH-1:0] c_ext, c_mx, hash_poly, hash_mx, hash_fold;
    logic signed [CT_W-1:0] cterm_s;
    logic [HASH_WIDTH:0]   rem_shift, rem_diff;

    function automatic logic [HASH_WIDTH-1:0] seed_of(input logic mode);
        seed_of = (mode == shbi_pkg::MODE_MX) ? HASH_WIDTH'(shbi_pkg::SEED_MX)
                                              : HASH_WIDTH'(shbi_pkg::SEED_POLY);
    endfunction

    assign seed     = seed_of(mode_reg);
    assign seed_new = seed_of(cfg_wdata[0]);

    // character term, sign-extended like a signed char
    assign c_ext   = HASH_WIDTH'($signed(char_byte));
    assign cterm_s = $signed(char_byte) * shbi_pkg::MX_MULT_C;
    assign c_mx    = HASH_WIDTH'(cterm_s);

    assign hash_poly = c_ext + (hash_reg << shbi_pkg::POLY_SHIFT) - hash_reg;
    assign hash_mx   = (hash_reg * HASH_WIDTH'(shbi_pkg::MX_MULT_H)) ^ c_mx;

    always_comb begin
        hash_fold = hash_reg;
        if (char_valid) begin
            hash_fold = (mode_reg == shbi_pkg::MODE_MX) ? hash_mx : hash_poly;
        end
    end

    always_comb begin
        hash_next = hash_reg;
        if (cfg_we && cfg_index == shbi_pkg::REG_HASH_MODE) begin
            hash_next = seed_new;
        end else if (cmd.item_accept) begin
            hash_next = word_end ? seed : hash_fold;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= shbi_pkg::MODE_POLY;
            buckets_reg <= HASH_WIDTH'(shbi_pkg::BUCKETS_RST);
            hash_reg    <= HASH_WIDTH'(shbi_pkg::SEED_POLY);
        end else begin
            hash_reg <= hash_next;
            if (cfg_we && cfg_index == shbi_pkg::REG_HASH_MODE) begin
                mode_reg <= cfg_wdata[0];
            end
            if (cfg_we && cfg_index == shbi_pkg::REG_BUCKETS) begin
                buckets_reg <= cfg_wdata;
            end
        end
    end

    // restoring remainder, one bit a step; a zero divisor leaves the dividend
    assign rem_shift = {rem_reg, dvd_reg[HASH_WIDTH-1]};
    assign rem_diff  = rem_shift - {1'b0, buckets_reg};

    always_ff @(posedge aclk) begin
        if (cmd.item_accept && word_end) begin
            raw_reg <= hash_fold;
            dvd_reg <= hash_fold;
            rem_reg <= '0;
        end else if (cmd.div_step) begin
            dvd_reg <= dvd_reg << 1;
            rem_reg <= rem_diff[HASH_WIDTH] ? rem_shift[HASH_WIDTH-1:0]
                                            : rem_diff[HASH_WIDTH-1:0];
        end
        if (cmd.out_load) begin
            out_raw_reg    <= raw_reg;
            out_bucket_reg <= rem_reg;
        end
    end

    assign raw_hash     = out_raw_reg;
    assign bucket_index = out_bucket_reg;

endmodule

// ===== hw/rtl/string_hash_bucket_index.sv =====
// Timing: a word with tlast clear is folded into the hash in the cycle it is taken.
// A word with tlast set yields its result on m_tdata after the remainder unit and the output register load.
// Throughput: one word per cycle within a string; an ending word holds s_tready low
// through the 32-step radix-2 remainder unit and until the output register is loaded.
// Reset (aresetn low, synchronous): hash_mode 0, table size 1024, hash at seed 0,
// output register empty.
module string_hash_bucket_index #(
    parameter int unsigned HASH_WIDTH = shbi_pkg::HASH_WIDTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    // input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,   // [7:0] char_byte
    input  logic                              s_tuser,   // [0] char_valid
    input  logic                              s_tlast,   // word_end

    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [2*HASH_WIDTH-1:0]           m_tdata,   // [31:0] raw_hash, [63:32] bucket_index

    // configuration writes
    input  logic                              cfg_we,
    input  logic [shbi_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [HASH_WIDTH-1:0]             cfg_wdata
);

    shbi_pkg::cmd_t        cmd;
    logic [HASH_WIDTH-1:0] raw_hash;
    logic [HASH_WIDTH-1:0] bucket_index;

    // Controller: accepts words while idle, sequences the remainder unit,
    // owns the output valid flag.
    shbi_ctrl #(
        .HASH_WIDTH (HASH_WIDTH)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .cmd      (cmd)
    );

    // Datapath: config registers, running hash, remainder unit, result register.
    shbi_dp #(
        .HASH_WIDTH (HASH_WIDTH)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .char_byte    (s_tdata),
        .char_valid   (s_tuser),
        .word_end     (s_tlast),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .raw_hash     (raw_hash),
        .bucket_index (bucket_index)
    );

    assign m_tdata = {bucket_index, raw_hash};

    // A finished result never overwrites one still waiting on m_tready.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_tvalid || m_tready))
        else $error("result register overwritten while stalled");

    // No input word is taken while the remainder unit is busy.
    a_busy_not_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_step |-> !s_tready)
        else $error("input ready during division");

    // An ending word closes the input until its result is formed.
    a_end_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=> (!s_tready && cmd.div_step))
        else $error("ending word did not start the remainder unit");

endmodule
